### sv/pcmt_pkg.sv
// Shared types and codes for the pending command match table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pcmt_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_TAKE   = 3'd1,
    FN_DELETE = 3'd2,
    FN_POP    = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Per-cycle commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic match_en;
    logic ins_en;
    logic srch_en;
    logic pop_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/pcmt_if.sv
// Handshake interfaces for the command and the result channel.
// Depends on pcmt_pkg for the field widths.
`default_nettype none

interface pcmt_cmd_if import pcmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  command_id;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, output func, output command_id, output entry_value,
                  input ready);
  modport sink   (input valid, input func, input command_id, input entry_value,
                  output ready);
endinterface

interface pcmt_rsp_if import pcmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output found_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input found_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

### sv/pcmt_cell.sv
// One slot of the table: holds a key and a value, registers its own match
// and takes part in the oldest-match chain. Depends on pcmt_pkg.
`default_nettype none

module pcmt_cell import pcmt_pkg::*; #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [KEY_W-1:0] cmd_key_i,
  input  wire logic [VAL_W-1:0] cmd_val_i,
  input  wire logic [KEY_W-1:0] nbr_key_i,
  input  wire logic [VAL_W-1:0] nbr_val_i,
  input  wire logic             hit_i,
  input  wire logic [VAL_W-1:0] hval_i,
  output logic                  hit_o,
  output logic [VAL_W-1:0]      hval_o,
  output logic [KEY_W-1:0]      key_o,
  output logic [VAL_W-1:0]      val_o
);

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic             match_q;
  logic             live;
  logic             shift;
  logic             ins_here;

  assign live     = CNT_W'(IDX) < count_i;
  assign ins_here = ctl_i.ins_en && (count_i == CNT_W'(IDX));

  // The first match seen along the chain wins; younger cells pass it on.
  assign hit_o  = hit_i | match_q;
  assign hval_o = hit_i ? hval_i : (match_q ? val_q : '0);

  // Everything at or after the removed slot moves down by one.
  assign shift = ctl_i.pop_en || (ctl_i.srch_en && hit_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.match_en) begin
      match_q <= live && (key_q == cmd_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_here) begin
      key_q <= cmd_key_i;
      val_q <= cmd_val_i;
    end else if (shift) begin
      key_q <= nbr_key_i;
      val_q <= nbr_val_i;
    end
  end

  assign key_o = key_q;
  assign val_o = val_q;

endmodule

`default_nettype wire

### sv/pending_command_match_table_unit.sv
// A command's transfer captures it in the idle cycle. The next cycle
// registers a parallel key compare in every cell. The cycle after that
// resolves the oldest match along the cell chain and does the shift or
// insert, and the result is registered as that resolving cycle completes. The
// oldest-match chain across TableDepth cells is the longest path. The
// result sits in an output register, so the next command is taken while an
// earlier result still waits. The resolving cycle holds for as long as that
// register is still occupied. A new command is taken only once the previous
// one has left the resolving cycle. No clearing pass is needed after reset.
// Top level; depends on pcmt_pkg, pcmt_if and pcmt_cell.
`default_nettype none

module pending_command_match_table_unit import pcmt_pkg::*; #(
  parameter int unsigned TableDepth = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcmt_cmd_if.sink   cmd_i,
  pcmt_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CntW-1:0]   count_q, count_d;

  logic              rsp_valid_q;
  logic [STAT_W-1:0] rsp_status_q, rsp_status_d;
  logic [VAL_W-1:0]  rsp_value_q, rsp_value_d;

  logic      out_free;
  logic      exec_fire;
  logic      full;
  logic      empty;
  logic      found;
  cell_ctl_t ctl;

  logic [TableDepth:0]            hit_c;
  logic [TableDepth:0][VAL_W-1:0] hval_c;
  logic [TableDepth-1:0][KEY_W-1:0] cell_key;
  logic [TableDepth-1:0][VAL_W-1:0] cell_val;

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign exec_fire = (state_q == S_EXEC) && out_free;
  assign full      = count_q == CntW'(TableDepth);
  assign empty     = count_q == '0;
  assign found     = hit_c[TableDepth];

  assign cmd_i.ready = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (cmd_i.valid) state_d = S_MATCH;
      S_MATCH: state_d = S_EXEC;
      S_EXEC:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      func_q <= cmd_i.func;
      key_q  <= cmd_i.command_id;
      val_q  <= cmd_i.entry_value;
    end
  end

  always_comb begin
    ctl.match_en = state_q == S_MATCH;
    ctl.ins_en   = exec_fire && (func_q == FN_INSERT) && !full;
    ctl.srch_en  = exec_fire && ((func_q == FN_TAKE) || (func_q == FN_DELETE));
    ctl.pop_en   = exec_fire && (func_q == FN_POP) && !empty;
  end

  always_comb begin
    count_d      = count_q;
    rsp_status_d = ST_OK;
    rsp_value_d  = '0;
    case (func_q)
      FN_INSERT: begin
        if (full) begin
          rsp_status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      FN_TAKE, FN_DELETE: begin
        if (found) begin
          count_d = count_q - 1'b1;
          if (func_q == FN_TAKE) rsp_value_d = hval_c[TableDepth];
        end else begin
          rsp_status_d = ST_MISSING;
        end
      end
      FN_POP: begin
        if (empty) begin
          rsp_status_d = ST_MISSING;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      FN_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rsp_status_q <= rsp_status_d;
      rsp_value_q  <= rsp_value_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_value = rsp_value_q;
  // Occupancy is reported at the field width of the result channel.
  assign rsp_o.occupancy   = OCC_W'(count_q);

  assign hit_c[0]  = 1'b0;
  assign hval_c[0] = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic [VAL_W-1:0] nbr_val;

    if (g == TableDepth - 1) begin : g_last
      assign nbr_key = '0;
      assign nbr_val = '0;
    end else begin : g_mid
      assign nbr_key = cell_key[g+1];
      assign nbr_val = cell_val[g+1];
    end

    pcmt_cell #(
      .CNT_W (CntW),
      .IDX   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .count_i   (count_q),
      .cmd_key_i (key_q),
      .cmd_val_i (val_q),
      .nbr_key_i (nbr_key),
      .nbr_val_i (nbr_val),
      .hit_i     (hit_c[g]),
      .hval_i    (hval_c[g]),
      .hit_o     (hit_c[g+1]),
      .hval_o    (hval_c[g+1]),
      .key_o     (cell_key[g]),
      .val_o     (cell_val[g])
    );
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("occupancy exceeds the table depth");

  a_count_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> $stable(count_q))
    else $error("occupancy changed outside command execution");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && func_q == FN_INSERT && full) |=> rsp_status_q == ST_FULL)
    else $error("insert into a full table was not refused");

  a_value_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q != ST_OK) |-> rsp_value_q == '0)
    else $error("non-zero value with a failing status");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised without an executed command");

endmodule

`default_nettype wire
